// File: rtl/lbps_pkg.sv
// Shared types and constants for the LED blink-pattern sequencer.
// Operation, symbol and register-index codes plus fixed field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lbps_pkg;

    // Fixed field widths
    localparam int OP_W      = 2;
    localparam int SLOT_W    = 5;
    localparam int SYM_W     = 3;
    localparam int POS_W     = 6;
    localparam int TICKS_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Input operations; code 3 changes nothing
    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_START = 2'd2
    } t_op;

    // Pattern symbols; codes 6 and 7 halt like the end code
    typedef enum logic [SYM_W-1:0] {
        SYM_END     = 3'd0,
        SYM_DASH    = 3'd1,
        SYM_DOT     = 3'd2,
        SYM_FLICKER = 3'd3,
        SYM_SPACE   = 3'd4,
        SYM_REPEAT  = 3'd5
    } t_sym;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DASH_TICKS    = 3'd0,
        CFG_DOT_TICKS     = 3'd1,
        CFG_FLICKER_TICKS = 3'd2,
        CFG_SYM_GAP_TICKS = 3'd3,
        CFG_CHR_GAP_TICKS = 3'd4,
        CFG_BEEP_FOLLOWS  = 3'd5
    } t_cfg_idx;

    // Reset values of the configuration registers
    localparam logic [TICKS_W-1:0] RST_DASH_TICKS    = 16'd30;
    localparam logic [TICKS_W-1:0] RST_DOT_TICKS     = 16'd10;
    localparam logic [TICKS_W-1:0] RST_FLICKER_TICKS = 16'd5;
    localparam logic [TICKS_W-1:0] RST_SYM_GAP_TICKS = 16'd10;
    localparam logic [TICKS_W-1:0] RST_CHR_GAP_TICKS = 16'd30;

endpackage : lbps_pkg

`default_nettype wire

// File: rtl/led_blink_pattern_sequencer_top.sv
// Top level of the LED blink-pattern sequencer: input beat register,
// sequencer state, pattern store with prefetch read port.
// Depends on lbps_pkg.
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+---------------------------------
//  in      | sink      | i_in_valid / o_in_stall    | i_operation, i_slot, i_symbol
//  out     | source    | o_out_valid / i_out_stall  | o_led_on, o_beep_enable, o_position
//  cfg     | sink      | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// Flow: one beat per clock sustained while the result is not stalled downstream; an accepted
//   input beat is loaded into the input register, then into the sequencer state that
//   drives the outputs.
// Reset: synchronous, active low; clears the sequencer state and the store's valid bits,
//   and loads the configuration registers with their reset values. No clearing pass: the store is usable at once.
// Stalls: o_in_stall rises only while a beat is held in the input register and the
//   pending result is stalled downstream; the output side holds its beat meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module led_blink_pattern_sequencer_top #(
    parameter int PATTERN_DEPTH = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input beat channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [lbps_pkg::OP_W-1:0]       i_operation,
    input  wire logic [lbps_pkg::SLOT_W-1:0]     i_slot,
    input  wire logic [lbps_pkg::SYM_W-1:0]      i_symbol,
    // result channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic                                 o_led_on,
    output logic                                 o_beep_enable,
    output logic [lbps_pkg::POS_W-1:0]           o_position,
    // configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [lbps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lbps_pkg::CFG_DAT_W-1:0]  i_cfg_data
);

    import lbps_pkg::*;

    // Store index width and pointer width (pointer may sit one past the last entry)
    localparam int IW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int PW = $clog2(PATTERN_DEPTH + 1);
    localparam logic [PW-1:0] PTR_END = PW'(PATTERN_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [TICKS_W-1:0] r_dash_ticks;
    logic [TICKS_W-1:0] r_dot_ticks;
    logic [TICKS_W-1:0] r_flicker_ticks;
    logic [TICKS_W-1:0] r_sym_gap_ticks;
    logic [TICKS_W-1:0] r_chr_gap_ticks;
    logic               r_beep_follows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dash_ticks    <= RST_DASH_TICKS;
            r_dot_ticks     <= RST_DOT_TICKS;
            r_flicker_ticks <= RST_FLICKER_TICKS;
            r_sym_gap_ticks <= RST_SYM_GAP_TICKS;
            r_chr_gap_ticks <= RST_CHR_GAP_TICKS;
            r_beep_follows  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DASH_TICKS:    r_dash_ticks    <= i_cfg_data;
                CFG_DOT_TICKS:     r_dot_ticks     <= i_cfg_data;
                CFG_FLICKER_TICKS: r_flicker_ticks <= i_cfg_data;
                CFG_SYM_GAP_TICKS: r_sym_gap_ticks <= i_cfg_data;
                CFG_CHR_GAP_TICKS: r_chr_gap_ticks <= i_cfg_data;
                CFG_BEEP_FOLLOWS:  r_beep_follows  <= i_cfg_data[0];
                default: ;  // indexes past the list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input register ahead of the sequencer state
    // ------------------------------------------------------------------
    logic              r_in_valid;
    logic [OP_W-1:0]   r_op;
    logic [SLOT_W-1:0] r_slot;
    logic [SYM_W-1:0]  r_sym;
    logic              r_out_valid;

    logic advance;  // the sequencer may take the held input beat this cycle
    logic go;       // a beat is processed this cycle
    logic in_take;

    assign advance    = !r_out_valid || !i_out_stall;
    assign go         = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            // the result beat is the sequencer state right after processing
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op   <= i_operation;
            r_slot <= i_slot;
            r_sym  <= i_symbol;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    logic [PW-1:0]      r_ptr,     n_ptr;
    logic               r_led,     n_led;
    logic               r_beep,    n_beep;
    logic [TICKS_W-1:0] r_elapsed, n_elapsed;
    logic [TICKS_W-1:0] r_seglen,  n_seglen;
    logic               r_done,    n_done;
    logic               r_cpp,     n_cpp;   // character pause pending
    logic               r_spp,     n_spp;   // symbol pause pending
    logic               r_rp,      n_rp;    // jump back to index zero pending

    // ------------------------------------------------------------------
    // Pattern store with prefetch: the registered read, with its write bypass,
    // always holds the entry at the current pointer, so a fetch needs no read in its cycle.
    // ------------------------------------------------------------------
    logic [SYM_W-1:0] mem [PATTERN_DEPTH];
    logic [PATTERN_DEPTH-1:0] r_vld;   // entry written since reset
    logic [SYM_W-1:0] r_rd;
    logic             r_rd_ok;         // r_rd holds a written, in-range entry
    logic             r_byp;           // pointed entry was written in the cycle the read was taken
    logic [SYM_W-1:0] r_byp_sym;

    logic             mem_we;
    logic [IW-1:0]    widx;
    logic [IW-1:0]    n_idx;
    logic             n_in_range;
    logic             slot_ok;
    logic [SYM_W-1:0] fsym;

    assign slot_ok    = (32'(r_slot) < 32'(PATTERN_DEPTH));
    assign widx       = IW'(r_slot);
    assign n_idx      = n_ptr[IW-1:0];
    assign n_in_range = (n_ptr < PTR_END);
    assign fsym       = r_byp ? r_byp_sym : (r_rd_ok ? r_rd : SYM_END);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[widx] <= r_sym;
        end
        r_rd      <= mem[n_idx];
        r_byp_sym <= r_sym;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_rd_ok <= 1'b0;
            r_byp   <= 1'b0;
        end else begin
            if (mem_we) begin
                r_vld[widx] <= 1'b1;
            end
            r_rd_ok <= n_in_range && r_vld[n_idx];
            r_byp   <= mem_we && n_in_range && (widx == n_idx);
        end
    end

    // ------------------------------------------------------------------
    // Next-state logic for one beat
    // ------------------------------------------------------------------
    logic               seg_start;
    logic [TICKS_W-1:0] seg_len;
    logic               seg_lit;
    logic [TICKS_W-1:0] e_inc;

    assign e_inc = r_elapsed + TICKS_W'(1);

    always_comb begin
        n_ptr     = r_ptr;
        n_led     = r_led;
        n_beep    = r_beep;
        n_elapsed = r_elapsed;
        n_seglen  = r_seglen;
        n_done    = r_done;
        n_cpp     = r_cpp;
        n_spp     = r_spp;
        n_rp      = r_rp;
        seg_start = 1'b0;
        seg_len   = '0;
        seg_lit   = 1'b0;
        mem_we    = 1'b0;

        if (go) begin
            unique case (r_op)
                OP_TICK: begin
                    if (!r_done && (r_elapsed != '0)) begin
                        // count the running segment; stop and go dark at its end
                        if (e_inc >= r_seglen) begin
                            n_elapsed = '0;
                            n_led     = 1'b0;
                            n_done    = 1'b1;
                        end else begin
                            n_elapsed = e_inc;
                        end
                    end else if (r_done) begin
                        if (r_cpp) begin
                            n_cpp     = 1'b0;
                            seg_start = 1'b1;
                            seg_len   = r_chr_gap_ticks;
                        end else if (r_spp) begin
                            n_spp     = 1'b0;
                            seg_start = 1'b1;
                            seg_len   = r_sym_gap_ticks;
                        end else if (r_rp) begin
                            n_rp  = 1'b0;
                            n_ptr = '0;
                        end else begin
                            unique case (fsym)
                                SYM_DASH, SYM_DOT, SYM_FLICKER: begin
                                    seg_start = 1'b1;
                                    seg_lit   = 1'b1;
                                    seg_len   = (fsym == SYM_DASH) ? r_dash_ticks :
                                                (fsym == SYM_DOT)  ? r_dot_ticks  :
                                                                     r_flicker_ticks;
                                    n_spp     = 1'b1;
                                    n_ptr     = r_ptr + PW'(1);
                                end
                                SYM_SPACE: begin
                                    n_cpp = 1'b1;
                                    n_ptr = r_ptr + PW'(1);
                                end
                                SYM_REPEAT: begin
                                    n_rp = 1'b1;
                                end
                                default: ;  // end and unknown codes halt here
                            endcase
                        end
                    end
                end
                OP_WRITE: begin
                    mem_we = slot_ok;
                end
                OP_START: begin
                    n_ptr  = '0;
                    n_done = 1'b1;
                end
                default: ;  // no-op beat reports the current state
            endcase
        end

        if (seg_start) begin
            n_seglen  = seg_len;
            n_elapsed = TICKS_W'(1);
            n_done    = 1'b0;
            n_led     = seg_lit;
            if (r_beep_follows) begin
                n_beep = seg_lit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_led     <= 1'b0;
            r_beep    <= 1'b0;
            r_elapsed <= '0;
            r_seglen  <= '0;
            r_done    <= 1'b0;
            r_cpp     <= 1'b0;
            r_spp     <= 1'b0;
            r_rp      <= 1'b0;
        end else begin
            r_ptr     <= n_ptr;
            r_led     <= n_led;
            r_beep    <= n_beep;
            r_elapsed <= n_elapsed;
            r_seglen  <= n_seglen;
            r_done    <= n_done;
            r_cpp     <= n_cpp;
            r_spp     <= n_spp;
            r_rp      <= n_rp;
        end
    end

    // State only moves together with the result beat, so it is the result register.
    assign o_out_valid   = r_out_valid;
    assign o_led_on      = r_led;
    assign o_beep_enable = r_beep;
    assign o_position    = POS_W'(r_ptr);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PTR_END)
        else $error("pointer ran past the end of the pattern store");

    a_one_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_cpp, r_spp, r_rp}))
        else $error("more than one pending fetch action");

    a_end_reads_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ptr == PTR_END) |-> (fsym == SYM_END))
        else $error("prefetch returned a symbol past the end of the store");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> ($stable(r_ptr) && $stable(r_led)
                                          && $stable(r_beep) && $stable(r_done)))
        else $error("sequencer state moved while the result beat was stalled");

endmodule : led_blink_pattern_sequencer_top

`default_nettype wire
